[design/polygon_frustum_reject_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the polygon frustum reject block
// Shared concurrent property forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POLYGON_FRUSTUM_REJECT_MACROS_SVH
`define POLYGON_FRUSTUM_REJECT_MACROS_SVH

// Same-cycle implication
`define PFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfr: same-cycle property failed");

// Next-cycle implication
`define PFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfr: next-cycle property failed");

`endif

[design/pfr_pkg.sv]
// ---------------------------------------------------------------------------
// pfr_pkg
// Types and constants shared by the polygon frustum reject modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

   // Register word indexes on the configuration port
   localparam logic [2:0] REG_CLIP_MODE     = 3'd0;
   localparam logic [2:0] REG_NEAR_PLANE    = 3'd1;
   localparam logic [2:0] REG_FAR_PLANE     = 3'd2;
   localparam logic [2:0] REG_HALF_WIDTH    = 3'd3;
   localparam logic [2:0] REG_HALF_HEIGHT   = 3'd4;
   localparam logic [2:0] REG_VIEW_DISTANCE = 3'd5;

   // Clip mode codes
   localparam logic MODE_DEPTH = 1'b0;
   localparam logic MODE_FULL  = 1'b1;

   // Register reset values
   localparam logic        RST_CLIP_MODE     = MODE_FULL;
   localparam logic [31:0] RST_NEAR_PLANE    = 32'd65536;
   localparam logic [31:0] RST_FAR_PLANE     = 32'd67108864;
   localparam logic [30:0] RST_HALF_WIDTH    = 31'd20971520;
   localparam logic [30:0] RST_HALF_HEIGHT   = 31'd15728640;
   localparam logic [30:0] RST_VIEW_DISTANCE = 31'd20971520;

   typedef struct packed {
      logic               clip_mode;
      logic signed [31:0] near_plane;
      logic signed [31:0] far_plane;
      logic [30:0]        half_width;
      logic [30:0]        half_height;
      logic [30:0]        view_distance;
   } cfg_type;

   // Per-vertex tests, and the per-polygon flags built from them
   typedef struct packed {
      logic before_near;
      logic past_far;
      logic inside_near;
      logic inside_far;
      logic right_of_left;
      logic left_of_right;
      logic above_bottom;
      logic below_top;
   } poly_flags_type;

   localparam poly_flags_type FLAGS_RESTART = '{
      before_near:   1'b1,
      past_far:      1'b1,
      inside_near:   1'b0,
      inside_far:    1'b0,
      right_of_left: 1'b0,
      left_of_right: 1'b0,
      above_bottom:  1'b0,
      below_top:     1'b0
   };

   typedef struct packed {
      logic           valid;
      logic           last;
      poly_flags_type hits;
   } vertex_status_type;

endpackage

`default_nettype wire

[design/pfr_csr.sv]
// ---------------------------------------------------------------------------
// pfr_csr
// Configuration registers behind an APB-style slave port.
// ---------------------------------------------------------------------------
`default_nettype none

module pfr_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output pfr_pkg::cfg_type      cfg
);

   pfr_pkg::cfg_type cfg_ff;
   pfr_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       word_idx;

   assign csr_pready = 1'b1;
   assign word_idx   = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (word_idx)
            pfr_pkg::REG_CLIP_MODE:     cfg_in.clip_mode     = csr_pwdata[0];
            pfr_pkg::REG_NEAR_PLANE:    cfg_in.near_plane    = $signed(csr_pwdata);
            pfr_pkg::REG_FAR_PLANE:     cfg_in.far_plane     = $signed(csr_pwdata);
            pfr_pkg::REG_HALF_WIDTH:    cfg_in.half_width    = csr_pwdata[30:0];
            pfr_pkg::REG_HALF_HEIGHT:   cfg_in.half_height   = csr_pwdata[30:0];
            pfr_pkg::REG_VIEW_DISTANCE: cfg_in.view_distance = csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_mode     <= pfr_pkg::RST_CLIP_MODE;
         cfg_ff.near_plane    <= $signed(pfr_pkg::RST_NEAR_PLANE);
         cfg_ff.far_plane     <= $signed(pfr_pkg::RST_FAR_PLANE);
         cfg_ff.half_width    <= pfr_pkg::RST_HALF_WIDTH;
         cfg_ff.half_height   <= pfr_pkg::RST_HALF_HEIGHT;
         cfg_ff.view_distance <= pfr_pkg::RST_VIEW_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (word_idx)
         pfr_pkg::REG_CLIP_MODE:     csr_prdata = {31'd0, cfg_ff.clip_mode};
         pfr_pkg::REG_NEAR_PLANE:    csr_prdata = cfg_ff.near_plane;
         pfr_pkg::REG_FAR_PLANE:     csr_prdata = cfg_ff.far_plane;
         pfr_pkg::REG_HALF_WIDTH:    csr_prdata = {1'b0, cfg_ff.half_width};
         pfr_pkg::REG_HALF_HEIGHT:   csr_prdata = {1'b0, cfg_ff.half_height};
         pfr_pkg::REG_VIEW_DISTANCE: csr_prdata = {1'b0, cfg_ff.view_distance};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/pfr_vertex_stage.sv]
// ---------------------------------------------------------------------------
// pfr_vertex_stage
// Registers the four frustum products and the depth tests of one vertex,
// then compares the products to give the side tests.
// ---------------------------------------------------------------------------
`default_nettype none

module pfr_vertex_stage #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire logic                   drain,
   input  wire logic [COORD_BITS-1:0]  vx,
   input  wire logic [COORD_BITS-1:0]  vy,
   input  wire logic [COORD_BITS-1:0]  vz,
   input  wire logic                   last_vertex,
   input  wire pfr_pkg::cfg_type       cfg,
   output pfr_pkg::vertex_status_type  status
);

   // Product width: signed coordinate times 31-bit unsigned
   localparam int PW = COORD_BITS + 31;
   // Sum width for the exact side compares
   localparam int SW = PW + 1;
   // Depth compare width
   localparam int CW = (COORD_BITS > 32) ? COORD_BITS : 32;

   logic signed [PW-1:0] x_ext, y_ext, z_ext;
   logic signed [PW-1:0] vd_ext, hw_ext, hh_ext;
   logic signed [CW-1:0] zc, near_c, far_c;

   logic signed [PW-1:0] xv_ff, yv_ff, xb_ff, yb_ff;
   logic signed [PW-1:0] xv_in, yv_in, xb_in, yb_in;
   logic [3:0]           depth_ff, depth_in;
   logic                 last_ff;
   logic                 valid_ff, valid_in;

   logic signed [SW-1:0] sum_rl, diff_lr, sum_ab, diff_bt;

   // Extend operands
   assign x_ext  = PW'($signed(vx));
   assign y_ext  = PW'($signed(vy));
   assign z_ext  = PW'($signed(vz));
   assign vd_ext = $signed(PW'(cfg.view_distance));
   assign hw_ext = $signed(PW'(cfg.half_width));
   assign hh_ext = $signed(PW'(cfg.half_height));

   assign zc     = CW'($signed(vz));
   assign near_c = CW'($signed(cfg.near_plane));
   assign far_c  = CW'($signed(cfg.far_plane));

   // Products and depth tests for the incoming vertex
   assign xv_in = x_ext * vd_ext;
   assign yv_in = y_ext * vd_ext;
   assign xb_in = z_ext * hw_ext;
   assign yb_in = z_ext * hh_ext;
   assign depth_in = {zc < near_c, zc > far_c, zc > near_c, zc < far_c};

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds unless a new vertex is loaded
   always_ff @(posedge clock) begin
      if (load) begin
         xv_ff    <= xv_in;
         yv_ff    <= yv_in;
         xb_ff    <= xb_in;
         yb_ff    <= yb_in;
         depth_ff <= depth_in;
         last_ff  <= last_vertex;
      end
   end

   // Side tests: x*vd > -hw*z, x*vd < hw*z, and the same for y
   assign sum_rl  = SW'(xv_ff) + SW'(xb_ff);
   assign diff_lr = SW'(xb_ff) - SW'(xv_ff);
   assign sum_ab  = SW'(yv_ff) + SW'(yb_ff);
   assign diff_bt = SW'(yb_ff) - SW'(yv_ff);

   always_comb begin
      status.valid              = valid_ff;
      status.last               = last_ff;
      status.hits.before_near   = depth_ff[3];
      status.hits.past_far      = depth_ff[2];
      status.hits.inside_near   = depth_ff[1];
      status.hits.inside_far    = depth_ff[0];
      status.hits.right_of_left = ~sum_rl[SW-1]  & (|sum_rl);
      status.hits.left_of_right = ~diff_lr[SW-1] & (|diff_lr);
      status.hits.above_bottom  = ~sum_ab[SW-1]  & (|sum_ab);
      status.hits.below_top     = ~diff_bt[SW-1] & (|diff_bt);
   end

endmodule

`default_nettype wire

[design/pfr_accum.sv]
// ---------------------------------------------------------------------------
// pfr_accum
// Gathers the per-polygon flags and registers the clipped decision on the
// last vertex of each polygon.
// ---------------------------------------------------------------------------
`default_nettype none

module pfr_accum (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pfr_pkg::vertex_status_type status,
   input  wire logic                       clip_mode,
   output logic                            take,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic                            clipped
);

   pfr_pkg::poly_flags_type flags_ff, flags_in, merged;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    clipped_ff, clipped_in;
   logic                    decision;

   // A last vertex waits while a result is still stalled
   assign take = status.valid & (~status.last | ~rsp_valid_ff | rsp_tready);

   // Merge this vertex into the polygon flags
   always_comb begin
      merged               = flags_ff;
      merged.before_near   = flags_ff.before_near   & status.hits.before_near;
      merged.past_far      = flags_ff.past_far      & status.hits.past_far;
      merged.inside_near   = flags_ff.inside_near   | status.hits.inside_near;
      merged.inside_far    = flags_ff.inside_far    | status.hits.inside_far;
      merged.right_of_left = flags_ff.right_of_left | status.hits.right_of_left;
      merged.left_of_right = flags_ff.left_of_right | status.hits.left_of_right;
      merged.above_bottom  = flags_ff.above_bottom  | status.hits.above_bottom;
      merged.below_top     = flags_ff.below_top     | status.hits.below_top;
   end

   // Clip decision from the merged flags
   always_comb begin
      case (clip_mode)
         pfr_pkg::MODE_DEPTH: decision = merged.before_near | merged.past_far;
         default: decision = ~merged.inside_near | ~merged.inside_far
                           | ~(merged.right_of_left & merged.left_of_right)
                           | ~(merged.above_bottom & merged.below_top);
      endcase
   end

   always_comb begin
      flags_in     = flags_ff;
      clipped_in   = clipped_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (take) begin
         if (status.last) begin
            flags_in     = pfr_pkg::FLAGS_RESTART;
            clipped_in   = decision;
            rsp_valid_in = 1'b1;
         end else begin
            flags_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= pfr_pkg::FLAGS_RESTART;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      clipped_ff <= clipped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign clipped    = clipped_ff;

endmodule

`default_nettype wire

[design/polygon_frustum_reject.sv]
// ---------------------------------------------------------------------------
// polygon_frustum_reject
// View frustum trivial reject: one clipped flag per streamed polygon.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  carries camera-space vertices (vx, vy, vz in tdata), req_tlast
//          on the final vertex of a polygon.
//   rsp_*  carries one transaction per polygon, rsp_tdata[0] = clipped.
//   csr_*  APB-style port: clip_mode, near, far, half width, half height
//          and view distance at byte addresses 0, 4, 8, 12, 16, 20.
// Throughput: one vertex per cycle while no last vertex is stalled.
// Path: the last vertex of a polygon is held in the product register when
//   accepted, and its result in the result register when that vertex
//   moves on.
// Reset: configuration registers return to their defaults, the polygon flags
//   restart and no result is pending.
// Stall: a stalled result holds in the output register; vertices that are
//   not last keep flowing, and input stops only when a last vertex must
//   wait behind an untaken result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "polygon_frustum_reject_macros.svh"

module polygon_frustum_reject #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Vertex stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: vx, vy, vz (low to high), zero padded to whole bytes
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                  req_tlast,
   // Result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: clipped in bit 0, rest zero
   output logic [7:0]                 rsp_tdata,
   // Configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [4:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   pfr_pkg::cfg_type           cfg;
   pfr_pkg::vertex_status_type status;
   logic                       load;
   logic                       take;
   logic                       clipped;

   // Accept a vertex when the product stage is free or moving on
   assign req_tready = ~status.valid | take;
   assign load       = req_tvalid & req_tready;

   pfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pfr_vertex_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_vertex (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .drain       (take),
      .vx          (req_tdata[COORD_BITS-1:0]),
      .vy          (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .vz          (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .last_vertex (req_tlast),
      .cfg         (cfg),
      .status      (status)
   );

   pfr_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .clip_mode  (cfg.clip_mode),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .clipped    (clipped)
   );

   assign rsp_tdata = {7'd0, clipped};

   // Input stalls only for a last vertex behind an untaken result
   `PFR_ASSERT_NOW(a_stall_cause, !req_tready, status.valid && status.last && rsp_tvalid && !rsp_tready)
   // A last vertex moving on always leaves a result
   `PFR_ASSERT_NEXT(a_last_gives_result, take && status.last, rsp_tvalid)
   // A result appears only after a last vertex moved on
   `PFR_ASSERT_NOW(a_result_origin, $rose(rsp_tvalid), $past(take && status.last))

endmodule

`default_nettype wire

[tb/tb_polygon_frustum_reject.sv]
// ---------------------------------------------------------------------------
// tb_polygon_frustum_reject
// Streams camera-space vertices through the frustum reject block and checks
// each clipped flag against a table value or a cycle-free predictor of the
// per-polygon flags. A directed table covers the plane and edge boundaries,
// the extremes, depth mode, a mode change inside a polygon and a zero view
// distance. Random polygons follow over register settings and idling phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_polygon_frustum_reject;

   localparam int          VERTICES_PER_PHASE = 114;
   localparam int          RANDOM_PHASES      = 8;
   localparam int          HOLD_OFF_CYCLES    = 6;
   localparam int          WATCHDOG_LIMIT     = 1000;
   localparam logic [2:0]  REG_SPARE          = 3'd6;
   localparam logic [31:0] Q_TWO              = 32'h0002_0000;
   localparam logic [31:0] S_MIN              = 32'h8000_0000;
   localparam logic [31:0] S_MAX              = 32'h7FFF_FFFF;
   localparam longint      BOUND_CLAMP        = 64'sd1 << 40;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata   = '0;   // vx, vy, vz (low to high)
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // clipped, then zero padding
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   polygon_frustum_reject #(.COORD_BITS(32)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Register copy and open-polygon flags of the prediction
   pfr_pkg::cfg_type frustum_cfg = '{pfr_pkg::RST_CLIP_MODE, pfr_pkg::RST_NEAR_PLANE,
                                     pfr_pkg::RST_FAR_PLANE, pfr_pkg::RST_HALF_WIDTH,
                                     pfr_pkg::RST_HALF_HEIGHT,
                                     pfr_pkg::RST_VIEW_DISTANCE};
   pfr_pkg::poly_flags_type polygon_flags = pfr_pkg::FLAGS_RESTART;
   logic clipped_due[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   // Directed stimulus: vertex rows, or register writes with the stream idle
   typedef enum logic {ROW_VERTEX, ROW_WRITE} row_kind_type;
   typedef struct {
      row_kind_type kind;
      logic [31:0]  vx;
      logic [31:0]  vy;
      logic [31:0]  vz;
      logic         last;
      logic         typed;
      logic         typed_clipped;
      logic [2:0]   reg_index;
      logic [31:0]  reg_value;
   } stim_row_type;

   // Register fields are unused on vertex rows; unchecked rows use the predictor
   stim_row_type directed_rows [30] = '{
      // full mode, reset registers: depth planes, extremes, exact edges
      '{ROW_VERTEX, 32'h0, 32'h0, 32'h0, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'h0, Q_TWO, 1, 1, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, S_MIN, S_MAX, S_MIN, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, S_MAX, S_MIN, S_MAX, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'h0, pfr_pkg::RST_NEAR_PLANE, 1, 1, 1,
        pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'h0, pfr_pkg::RST_FAR_PLANE, 1, 1, 1,
        pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'hFFFE_0000, 32'h0, Q_TWO, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, Q_TWO, 32'h0, Q_TWO, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'h0001_8000, Q_TWO, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'hFFFE_8000, Q_TWO, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      // two outside vertices straddling the frustum
      '{ROW_VERTEX, 32'hFFF6_0000, 32'h0, Q_TWO, 0, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h000A_0000, 32'h0, Q_TWO, 1, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      // depth mode, written with spare upper bits set
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'hFFFF_FFFE},
      '{ROW_VERTEX, S_MIN, S_MIN, Q_TWO, 1, 1, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, 32'h0, 32'h0, 32'hFFFF_0000, 1, 1, 1, pfr_pkg::REG_CLIP_MODE, 32'h0},
      // mode switched to full inside a polygon: the last vertex decides
      '{ROW_VERTEX, 32'h0, 32'h0, pfr_pkg::RST_NEAR_PLANE, 0, 0, 0,
        pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_CLIP_MODE,
        32'(pfr_pkg::MODE_FULL)},
      '{ROW_VERTEX, 32'h0, 32'h0, pfr_pkg::RST_NEAR_PLANE, 1, 1, 1,
        pfr_pkg::REG_CLIP_MODE, 32'h0},
      // zero view distance
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_VIEW_DISTANCE, 32'h0},
      '{ROW_VERTEX, 32'h0005_0000, 32'h0005_0000, Q_TWO, 1, 0, 0,
        pfr_pkg::REG_CLIP_MODE, 32'h0},
      // widest registers, plus a write to an unmapped word
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_NEAR_PLANE, S_MIN},
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_FAR_PLANE, S_MAX},
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_HALF_WIDTH, 32'hFFFF_FFFF},
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_HALF_HEIGHT, S_MAX},
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, pfr_pkg::REG_VIEW_DISTANCE, S_MAX},
      '{ROW_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, REG_SPARE, 32'hFFFF_FFFF},
      '{ROW_VERTEX, S_MAX, S_MIN, 32'h1, 1, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, S_MIN, S_MAX, S_MAX, 0, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'h0},
      '{ROW_VERTEX, S_MAX, S_MIN, S_MIN, 1, 0, 0, pfr_pkg::REG_CLIP_MODE, 32'h0}
   };

   // Update the register copy, dropping bits beyond each register's width
   function automatic void apply_register(logic [2:0] index, logic [31:0] value);
      case (index)
         pfr_pkg::REG_CLIP_MODE:     frustum_cfg.clip_mode     = value[0];
         pfr_pkg::REG_NEAR_PLANE:    frustum_cfg.near_plane    = value;
         pfr_pkg::REG_FAR_PLANE:     frustum_cfg.far_plane     = value;
         pfr_pkg::REG_HALF_WIDTH:    frustum_cfg.half_width    = value[30:0];
         pfr_pkg::REG_HALF_HEIGHT:   frustum_cfg.half_height   = value[30:0];
         pfr_pkg::REG_VIEW_DISTANCE: frustum_cfg.view_distance = value[30:0];
         default: ;
      endcase
   endfunction

   // Fold one vertex into the polygon flags; on the last one give the flag
   function automatic bit fold_vertex(input logic signed [31:0] vx, vy, vz,
                                      input logic last, output logic clipped);
      longint x, y, z, vd, hw, hh, near_z, far_z, xv, yv, xb, yb;
      x      = vx;
      y      = vy;
      z      = vz;
      vd     = frustum_cfg.view_distance;
      hw     = frustum_cfg.half_width;
      hh     = frustum_cfg.half_height;
      near_z = $signed(frustum_cfg.near_plane);
      far_z  = $signed(frustum_cfg.far_plane);
      // products stay below 2^62, so 64 bits hold them exactly
      xv = x * vd;
      yv = y * vd;
      xb = hw * z;
      yb = hh * z;
      if (!(z < near_z)) polygon_flags.before_near   = 1'b0;
      if (!(z > far_z))  polygon_flags.past_far      = 1'b0;
      if (z > near_z)    polygon_flags.inside_near   = 1'b1;
      if (z < far_z)     polygon_flags.inside_far    = 1'b1;
      if (-xb < xv)      polygon_flags.right_of_left = 1'b1;
      if (xv < xb)       polygon_flags.left_of_right = 1'b1;
      if (-yb < yv)      polygon_flags.above_bottom  = 1'b1;
      if (yv < yb)       polygon_flags.below_top     = 1'b1;
      clipped = 1'b0;
      if (!last) return 1'b0;
      if (frustum_cfg.clip_mode == pfr_pkg::MODE_DEPTH) begin
         clipped = polygon_flags.before_near || polygon_flags.past_far;
      end else begin
         clipped = !polygon_flags.inside_near || !polygon_flags.inside_far
                || !(polygon_flags.right_of_left && polygon_flags.left_of_right)
                || !(polygon_flags.above_bottom && polygon_flags.below_top);
      end
      polygon_flags = pfr_pkg::FLAGS_RESTART;
      return 1'b1;
   endfunction

   // Random coordinate around a side bound: on it, across it, or anywhere
   function automatic logic [31:0] pick_side(longint bound);
      int     off, scale;
      longint v;
      if (bound > BOUND_CLAMP) bound = BOUND_CLAMP;
      if (bound < -BOUND_CLAMP) bound = -BOUND_CLAMP;
      off = $urandom_range(0, 2);
      off = off - 1;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = bound + off;
         2: v = -bound + off;
         default: begin
            scale = $urandom_range(0, 300);
            scale = scale - 150;
            v = (bound * scale) / 100;
         end
      endcase
      return v[31:0];
   endfunction

   // Random vertex shaped by the current planes and bounds
   function automatic void pick_vertex(output logic [31:0] vx, vy, vz);
      int     off;
      longint near_z, far_z, lo, hi, z, vd_eff, v;
      near_z = $signed(frustum_cfg.near_plane);
      far_z  = $signed(frustum_cfg.far_plane);
      lo     = (near_z < far_z) ? near_z : far_z;
      hi     = (near_z < far_z) ? far_z : near_z;
      off    = $urandom_range(0, 2);
      off    = off - 1;
      case ($urandom_range(0, 7))
         0: v = $urandom;
         1: v = near_z + off;
         2: v = far_z + off;
         default: v = lo - 8 + (longint'($urandom) % (hi - lo + 17));
      endcase
      vz     = v[31:0];
      z      = $signed(vz);
      vd_eff = (frustum_cfg.view_distance == '0) ? 1 : frustum_cfg.view_distance;
      vx     = pick_side((longint'(frustum_cfg.half_width) * z) / vd_eff);
      vy     = pick_side((longint'(frustum_cfg.half_height) * z) / vd_eff);
   endfunction

   // Offer one vertex, hold it until taken, then predict its result
   task automatic send_vertex(logic [31:0] vx, vy, vz, logic last,
                              logic typed, logic typed_clipped);
      logic clipped;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vz, vy, vx};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (fold_vertex(vx, vy, vz, last, clipped)) begin
         clipped_due.push_back(typed ? typed_clipped : clipped);
      end
   endtask

   // Stop the vertex stream and let every result out of the pipeline
   task automatic go_idle();
      req_tvalid <= 1'b0;
      while (clipped_due.size() != 0) @(posedge clock);
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
   endtask

   // Setup and access phases, then the port is deselected
   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register set of one random phase: reset values, two extremes, random
   task automatic setup_phase(int phase);
      logic [31:0] vals [6];
      logic [31:0] base;
      case (phase)
         0: vals = '{32'(pfr_pkg::RST_CLIP_MODE), pfr_pkg::RST_NEAR_PLANE,
                     pfr_pkg::RST_FAR_PLANE, 32'(pfr_pkg::RST_HALF_WIDTH),
                     32'(pfr_pkg::RST_HALF_HEIGHT), 32'(pfr_pkg::RST_VIEW_DISTANCE)};
         1: vals = '{32'(pfr_pkg::MODE_FULL), S_MIN, S_MAX, S_MAX, S_MAX, S_MAX};
         2: vals = '{32'(pfr_pkg::MODE_DEPTH), S_MAX, S_MIN, 32'h0, 32'h0, 32'h1};
         default: begin
            vals[0] = $urandom;
            base    = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : $urandom_range(0, 32'h8_0000) - 32'h1_0000;
            vals[1] = base;
            vals[2] = base + $urandom_range(0, 32'h0800_0000);
            if ($urandom_range(0, 7) == 0) vals[2] = $urandom;
            for (int i = 3; i < 6; i++) begin
               case ($urandom_range(0, 3))
                  0: vals[i] = $urandom;
                  1: vals[i] = $urandom_range(1, 32'h0001_0000);
                  default: vals[i] = $urandom_range(32'h0001_0000, 32'h03E8_0000);
               endcase
            end
         end
      endcase
      for (int i = 0; i < 6; i++) csr_write(3'(i), vals[i]);
   endtask

   // Take results and compare with the oldest expectation; stall at random
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (clipped_due.size() == 0) begin
            $error("unexpected result transaction, clipped %0b", rsp_tdata[0]);
            error_count++;
         end else begin
            want = clipped_due.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("clipped: expected %0b, got %0b", want, rsp_tdata[0]);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // End the run when no transaction has moved for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int          sent;
      int          count;
      logic        noise;
      logic [31:0] vx, vy, vz;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            go_idle();
            csr_write(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_vertex(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].vz,
                        directed_rows[i].last, directed_rows[i].typed,
                        directed_rows[i].typed_clipped);
         end
      end

      // random polygons, cycling through the idling phases
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         go_idle();
         setup_phase(phase);
         send_idle_pct = (phase % 4 == 1) ? 48 : (phase % 4 == 3) ? 24 : 0;
         rsp_stall_pct = (phase % 4 == 2) ? 48 : (phase % 4 == 3) ? 24 : 0;
         sent = 0;
         while (sent < VERTICES_PER_PHASE) begin
            count = $urandom_range(1, 6);
            noise = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < count; k++) begin
               if (noise) begin
                  vx = $urandom;
                  vy = $urandom;
                  vz = $urandom;
               end else begin
                  pick_vertex(vx, vy, vz);
               end
               send_vertex(vx, vy, vz, noise ? 1'($urandom) : (k == count - 1), 1'b0, 1'b0);
            end
            sent += count;
         end
      end

      go_idle();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
